// ===== hw/rtl/afbe_pkg.sv =====
`timescale 1ns / 1ps

package afbe_pkg;

   localparam logic [7:0] START_DELIM = 8'h7E;
   localparam logic [7:0] ESCAPE_MARK = 8'h7D;
   localparam logic [7:0] XON_CODE    = 8'h11;
   localparam logic [7:0] XOFF_CODE   = 8'h13;
   localparam logic [7:0] FLIP_MASK   = 8'h20;

   localparam logic DIR_ESCAPE   = 1'b0;
   localparam logic DIR_UNESCAPE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One queued operation: the final byte, and whether the escape mark goes first.
   typedef struct packed {
      logic [7:0] data;
      logic       stuff;
   } op_type;

   function automatic logic needs_stuffing(input logic [7:0] b);
      return (b == START_DELIM) || (b == ESCAPE_MARK) || (b == XON_CODE) || (b == XOFF_CODE);
   endfunction

endpackage

// ===== hw/rtl/afbe_if.sv =====
`timescale 1ns / 1ps

interface afbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       frame_start;

   modport source (output valid, output in_byte, output frame_start, input ready);
   modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface afbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hw/rtl/afbe_front.sv =====
`timescale 1ns / 1ps

module afbe_front import afbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       frame_start,
   input  logic       queue_full,
   output logic       push,
   output op_type     push_op
);

   logic direction_ff, direction_in;
   logic pending_ff, pending_in;
   logic accept;
   logic swallow;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      pending_in   = pending_ff;
      swallow      = 1'b0;
      push_op.data  = in_byte;
      push_op.stuff = 1'b0;
      if (frame_start) begin
         pending_in = 1'b0;
      end else if (direction_ff == DIR_ESCAPE) begin
         pending_in    = 1'b0;
         push_op.stuff = needs_stuffing(in_byte);
         if (push_op.stuff) begin
            push_op.data = in_byte ^ FLIP_MASK;
         end
      end else if (pending_ff) begin
         pending_in   = 1'b0;
         push_op.data = in_byte ^ FLIP_MASK;
      end else if (in_byte == ESCAPE_MARK) begin
         pending_in = 1'b1;
         swallow    = 1'b1;
      end
   end

   assign push         = accept && !swallow;
   assign direction_in = csr_write_enable ? csr_write_data : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ESCAPE;
         pending_ff   <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         if (accept) begin
            pending_ff <= pending_in;
         end
      end
   end

endmodule

// ===== hw/rtl/afbe_queue.sv =====
`timescale 1ns / 1ps

module afbe_queue import afbe_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type head_op
);

   op_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/afbe_back.sv =====
`timescale 1ns / 1ps

module afbe_back import afbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  op_type     head_op,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       run_last
);

   logic       valid_ff, valid_in;
   logic       half_ff, half_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (head_op.stuff && !half_ff) begin
               byte_in = ESCAPE_MARK;
               last_in = 1'b0;
               half_in = 1'b1;
            end else begin
               byte_in = head_op.data;
               last_in = 1'b1;
               half_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign run_last  = last_ff;

endmodule

// ===== hw/rtl/api_frame_byte_escaper_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Words carried
// req_bus   in         in_byte, frame_start
// rsp_bus   out        out_byte, run_last
// csr_*     in         direction, one bit, written by enable
//
// Each input word is taken while the queue is not full; an escaped byte leaves as two output words.
// Output runs at one word per cycle while ready; a stuffed byte puts its escape mark first.
// Input reaches the output through the two-entry queue and the output register.
// Reset is synchronous and clears the direction, the pending flag, the queue and the output.
// Input stalls only when the queue is full; output stalls hold accepted work in the queue.

module api_frame_byte_escaper_top import afbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   afbe_req_if.sink   req_bus,
   afbe_rsp_if.source rsp_bus
);

   logic   push, pop, full, empty;
   op_type push_op, head_op;

   afbe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (req_bus.valid),
      .in_ready         (req_bus.ready),
      .in_byte          (req_bus.in_byte),
      .frame_start      (req_bus.frame_start),
      .queue_full       (full),
      .push             (push),
      .push_op          (push_op)
   );

   afbe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .empty   (empty),
      .head_op (head_op)
   );

   afbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head_op   (head_op),
      .pop       (pop),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_byte  (rsp_bus.out_byte),
      .run_last  (rsp_bus.run_last)
   );

endmodule

// ===== tb/tb_api_frame_byte_escaper_top.sv =====
`timescale 1ns / 1ps

module tb_api_frame_byte_escaper_top;
   import afbe_pkg::*;

   typedef struct {
      logic [7:0] in_byte;
      logic       frame_start;
   } raw_word_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
   } coded_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   afbe_req_if req_bus ();
   afbe_rsp_if rsp_bus ();

   api_frame_byte_escaper_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   raw_word_type   raw_word_q[$];
   coded_word_type coded_word_q[$];

   logic dir_now;
   logic pend_flip;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   raw_made;
   int   mismatch_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void push_coded(input logic [7:0] b, input logic last);
      coded_word_type c;
      c.out_byte = b;
      c.run_last = last;
      coded_word_q.push_back(c);
   endfunction

   // Works out the output words caused by one accepted input word.
   function automatic void code_frame_byte(input logic [7:0] b, input logic first);
      if (first) begin
         pend_flip = 1'b0;
         push_coded(b, 1'b1);
      end else if (dir_now == DIR_ESCAPE) begin
         pend_flip = 1'b0;
         if (b == START_DELIM || b == ESCAPE_MARK || b == XON_CODE || b == XOFF_CODE) begin
            push_coded(ESCAPE_MARK, 1'b0);
            push_coded(b ^ FLIP_MASK, 1'b1);
         end else begin
            push_coded(b, 1'b1);
         end
      end else if (pend_flip) begin
         pend_flip = 1'b0;
         push_coded(b ^ FLIP_MASK, 1'b1);
      end else if (b == ESCAPE_MARK) begin
         pend_flip = 1'b1;
      end else begin
         push_coded(b, 1'b1);
      end
   endfunction

   always @(posedge clock) begin : drive_req
      raw_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            code_frame_byte(req_bus.in_byte, req_bus.frame_start);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (raw_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               w = raw_word_q.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.in_byte     <= w.in_byte;
               req_bus.frame_start <= w.frame_start;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_rsp
      coded_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (coded_word_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h run_last %b",
                                      rsp_bus.out_byte, rsp_bus.run_last));
         end else begin
            want = coded_word_q.pop_front();
            if (rsp_bus.out_byte !== want.out_byte) begin
               report_mismatch($sformatf("out_byte %h, wanted %h",
                                         rsp_bus.out_byte, want.out_byte));
            end
            if (rsp_bus.run_last !== want.run_last) begin
               report_mismatch($sformatf("run_last %b, wanted %b on byte %h",
                                         rsp_bus.run_last, want.run_last, want.out_byte));
            end
         end
      end
   end

   task automatic push_raw(input logic [7:0] b, input logic first);
      raw_word_type w;
      w.in_byte     = b;
      w.frame_start = first;
      raw_word_q.push_back(w);
      raw_made++;
   endtask

   function automatic logic [7:0] pick_special();
      case ($urandom_range(3))
         0: return START_DELIM;
         1: return ESCAPE_MARK;
         2: return XON_CODE;
         default: return XOFF_CODE;
      endcase
   endfunction

   // Mostly well-formed frames with a heavy share of special bytes and escape pairs,
   // plus lone escape marks and stray frame starts.
   task automatic make_frame();
      int body_len;
      body_len = $urandom_range(1, 12);
      push_raw(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : START_DELIM, 1'b1);
      repeat (body_len) begin
         case ($urandom_range(9))
            0, 1, 2: push_raw(pick_special(), 1'b0);
            3, 4: begin
               push_raw(ESCAPE_MARK, 1'b0);
               push_raw(($urandom_range(1) == 0) ? (pick_special() ^ FLIP_MASK)
                                                 : 8'($urandom_range(255)), 1'b0);
            end
            5: push_raw(ESCAPE_MARK, 1'b0);
            6: push_raw(8'($urandom_range(255)), 1'b1);
            default: push_raw(8'($urandom_range(255)), 1'b0);
         endcase
      end
   endtask

   task automatic wait_quiet();
      while (raw_word_q.size() != 0 || req_bus.valid || coded_word_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_direction(input logic value);
      wait_quiet();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dir_now = value;
      @(negedge clock);
   endtask

   task automatic run_random(input logic dir, input int snd_pct, input int rcv_pct,
                             input int count);
      write_direction(dir);
      send_idle_pct  = snd_pct;
      recv_stall_pct = rcv_pct;
      raw_made = 0;
      while (raw_made < count) begin
         make_frame();
      end
   endtask

   initial begin
      #5_000_000;
      $display("api_frame_byte_escaper_top: mismatch");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.in_byte      = 8'h00;
      req_bus.frame_start  = 1'b0;
      rsp_bus.ready        = 1'b0;
      dir_now              = DIR_ESCAPE;
      pend_flip            = 1'b0;
      send_idle_pct        = 7;
      recv_stall_pct       = 88;
      mismatch_count       = 0;
      raw_made             = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_direction(DIR_ESCAPE);
      push_raw(START_DELIM, 1'b1);
      push_raw(START_DELIM, 1'b0);
      push_raw(ESCAPE_MARK, 1'b0);
      push_raw(XON_CODE, 1'b0);
      push_raw(XOFF_CODE, 1'b0);
      push_raw(8'h00, 1'b0);
      push_raw(8'hFF, 1'b0);
      push_raw(ESCAPE_MARK, 1'b1);
      push_raw(8'h5A, 1'b0);

      write_direction(DIR_UNESCAPE);
      push_raw(START_DELIM, 1'b1);
      push_raw(ESCAPE_MARK, 1'b0);
      push_raw(8'h5E, 1'b0);
      push_raw(ESCAPE_MARK, 1'b0);
      push_raw(ESCAPE_MARK, 1'b0);
      push_raw(ESCAPE_MARK, 1'b0);
      push_raw(ESCAPE_MARK, 1'b1);
      push_raw(8'h31, 1'b0);
      push_raw(8'hFF, 1'b0);
      push_raw(8'h00, 1'b0);
      push_raw(ESCAPE_MARK, 1'b0);

      // A pending escape left by unescaping must be dropped by the first escaped word.
      write_direction(DIR_ESCAPE);
      push_raw(8'h41, 1'b0);
      write_direction(DIR_UNESCAPE);
      push_raw(8'h61, 1'b0);

      run_random(DIR_UNESCAPE, 7, 88, 120);
      run_random(DIR_ESCAPE, 7, 88, 115);
      run_random(DIR_ESCAPE, 88, 7, 115);
      run_random(DIR_UNESCAPE, 88, 7, 115);
      run_random(DIR_UNESCAPE, 0, 0, 115);
      run_random(DIR_ESCAPE, 0, 0, 120);

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("api_frame_byte_escaper_top: match");
      end else begin
         $display("api_frame_byte_escaper_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/afbe_pkg.sv
hw/rtl/afbe_if.sv
hw/rtl/afbe_front.sv
hw/rtl/afbe_queue.sv
hw/rtl/afbe_back.sv
hw/rtl/api_frame_byte_escaper_top.sv
tb/tb_api_frame_byte_escaper_top.sv
